// ----- hdl/sdspi_pkg.sv -----
// Shared types and constants for the SD SPI command engine.
`timescale 1ns / 1ps
package sdspi_pkg;

  localparam logic [1:0] OP_CMD  = 2'd0;
  localparam logic [1:0] OP_INIT = 2'd1;
  localparam logic [1:0] OP_XFER = 2'd2;

  localparam logic [1:0] KIND_R1  = 2'd0;
  localparam logic [1:0] KIND_R1B = 2'd1;
  localparam logic [1:0] KIND_R2  = 2'd2;
  localparam logic [1:0] KIND_R3  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_RESP = 2'd1;
  localparam logic [1:0] ST_RETRIES = 2'd2;
  localparam logic [1:0] ST_VOLTAGE = 2'd3;

  localparam logic [2:0] FS_GO_IDLE = 3'd0;
  localparam logic [2:0] FS_IDLE_WT = 3'd1;
  localparam logic [2:0] FS_OCR     = 3'd2;
  localparam logic [2:0] FS_SET_LEN = 3'd3;
  localparam logic [2:0] FS_PLAIN   = 3'd4;

  localparam logic [2:0] CFG_POLL_LIMIT  = 3'd0;
  localparam logic [2:0] CFG_RETRY_LIMIT = 3'd1;
  localparam logic [2:0] CFG_BLOCK_LEN   = 3'd2;
  localparam logic [2:0] CFG_OCR_MASK    = 3'd3;
  localparam logic [2:0] CFG_WAKE_SEL    = 3'd4;
  localparam logic [2:0] CFG_WAKE_DESEL  = 3'd5;

  localparam logic [7:0] CRC_BYTE  = 8'h95;
  localparam logic [7:0] IDLE_BYTE = 8'hFF;
  localparam logic [7:0] CMD_START = 8'h40;
  localparam logic [5:0] IDX_MASK  = 6'h3F;
  localparam logic [7:0] BIT7      = 8'h80;

  // Classified item passed from the front part to the sequencer.
  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  command_index;
    logic [31:0] argument;
    logic [1:0]  response_kind;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    logic        transfer_valid;
    logic [7:0]  tx_byte;
    logic        card_selected;
    logic        done_res;
    logic [1:0]  status;
    logic [2:0]  failed_step;
    logic [39:0] response_word;
  } result_t;

  typedef struct packed {
    logic [15:0] poll_limit;
    logic [15:0] idle_retry_limit;
    logic [31:0] block_length;
    logic [7:0]  ocr_voltage_mask;
    logic [7:0]  wake_select_bytes;
    logic [7:0]  wake_deselect_bytes;
  } cfg_t;

endpackage

// ----- hdl/sdspi_if.sv -----
// Valid/ready channel interfaces for items and results.
`timescale 1ns / 1ps
interface sdspi_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [5:0]  command_index;
  logic [31:0] argument;
  logic [1:0]  response_kind;
  logic [7:0]  rx_byte;
  modport source (output valid, operation, command_index, argument, response_kind, rx_byte,
                  input ready);
  modport sink (input valid, operation, command_index, argument, response_kind, rx_byte,
                output ready);
endinterface

interface sdspi_out_if;
  logic        valid;
  logic        ready;
  logic        transfer_valid;
  logic [7:0]  tx_byte;
  logic        card_selected;
  logic        done_res;
  logic [1:0]  status;
  logic [2:0]  failed_step;
  logic [39:0] response_word;
  modport source (output valid, transfer_valid, tx_byte, card_selected, done_res, status,
                  failed_step, response_word, input ready);
  modport sink (input valid, transfer_valid, tx_byte, card_selected, done_res, status,
                failed_step, response_word, output ready);
endinterface

// ----- hdl/sdspi_front.sv -----
// Front part: accepts items, masks unknown operations, two-entry queue to the sequencer.
`timescale 1ns / 1ps
module sdspi_front
  import sdspi_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  q_valid,
  input  logic  q_pop,
  output item_t q_item
);

  item_t       mem_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r;
  logic        push;
  item_t       cls;

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    cls = in_item;
    // Operation 3 behaves as an ignored item everywhere; fold it into a fixed code.
    if (in_item.op == 2'd3) begin
      cls.op = 2'd3;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ----- hdl/sdspi_seq.sv -----
// Back part: the command and init sequencer with a registered result stage.
`timescale 1ns / 1ps
module sdspi_seq
  import sdspi_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    q_valid,
  output logic    q_pop,
  input  item_t   q_item,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_WAKE_SEL, PH_WAKE_DESEL, PH_SEND, PH_POLL, PH_CAPTURE, PH_BUSY, PH_BUSY_TAIL
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  init_step_r, init_step_nxt;
  logic [7:0]  byte_counter_r, byte_counter_nxt;
  logic [15:0] poll_counter_r, poll_counter_nxt;
  logic [15:0] retry_counter_r, retry_counter_nxt;
  logic [39:0] command_latch_r, command_latch_nxt;
  logic [39:0] response_shift_r, response_shift_nxt;
  logic [2:0]  bytes_remaining_r, bytes_remaining_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic        init_r, init_nxt;
  logic        res_valid_r;
  result_t     res_r, res_nxt;

  logic [7:0]  bc_inc;
  logic [15:0] pc_inc;

  assign q_pop     = q_valid && (!res_valid_r || res_ready);
  assign res_valid = res_valid_r;
  assign res       = res_r;
  assign bc_inc    = byte_counter_r + 8'd1;
  assign pc_inc    = poll_counter_r + 16'd1;

  always_comb begin
    logic       fin, ok, st_cmd;
    logic [5:0] c_idx;
    logic [31:0] c_arg;
    logic [1:0] c_kind;
    logic [1:0] f_st;
    logic [2:0] f_fs;
    logic       fail;
    phase_nxt           = phase_r;
    init_step_nxt       = init_step_r;
    byte_counter_nxt    = byte_counter_r;
    poll_counter_nxt    = poll_counter_r;
    retry_counter_nxt   = retry_counter_r;
    command_latch_nxt   = command_latch_r;
    response_shift_nxt  = response_shift_r;
    bytes_remaining_nxt = bytes_remaining_r;
    kind_nxt            = kind_r;
    init_nxt            = init_r;
    res_nxt             = '0;
    fin = 1'b0; ok = 1'b0; st_cmd = 1'b0;
    c_idx = '0; c_arg = '0; c_kind = KIND_R1;
    f_st = ST_OK; f_fs = FS_GO_IDLE; fail = 1'b0;

    if (phase_r == PH_IDLE) begin
      if (q_item.op == OP_CMD) begin
        init_nxt = 1'b0;
        st_cmd = 1'b1; c_idx = q_item.command_index;
        c_arg = q_item.argument; c_kind = q_item.response_kind;
      end else if (q_item.op == OP_INIT) begin
        init_nxt = 1'b1;
        init_step_nxt = 3'd0;
        byte_counter_nxt = 8'd0;
        if (cfg.wake_select_bytes != 8'd0) begin
          phase_nxt = PH_WAKE_SEL;
          res_nxt.transfer_valid = 1'b1; res_nxt.tx_byte = IDLE_BYTE;
          res_nxt.card_selected = 1'b1;
        end else if (cfg.wake_deselect_bytes != 8'd0) begin
          phase_nxt = PH_WAKE_DESEL;
          res_nxt.transfer_valid = 1'b1; res_nxt.tx_byte = IDLE_BYTE;
        end else begin
          init_step_nxt = 3'd0; st_cmd = 1'b1;
        end
      end
    end else if (q_item.op == OP_XFER) begin
      case (phase_r)
        PH_WAKE_SEL: begin
          byte_counter_nxt = bc_inc;
          if (bc_inc < cfg.wake_select_bytes) begin
            res_nxt.transfer_valid = 1'b1; res_nxt.tx_byte = IDLE_BYTE;
            res_nxt.card_selected = 1'b1;
          end else begin
            byte_counter_nxt = 8'd0;
            if (cfg.wake_deselect_bytes != 8'd0) begin
              phase_nxt = PH_WAKE_DESEL;
              res_nxt.transfer_valid = 1'b1; res_nxt.tx_byte = IDLE_BYTE;
            end else begin
              init_step_nxt = 3'd0; st_cmd = 1'b1;
            end
          end
        end
        PH_WAKE_DESEL: begin
          byte_counter_nxt = bc_inc;
          if (bc_inc < cfg.wake_deselect_bytes) begin
            res_nxt.transfer_valid = 1'b1; res_nxt.tx_byte = IDLE_BYTE;
          end else begin
            init_step_nxt = 3'd0; st_cmd = 1'b1;
          end
        end
        PH_SEND: begin
          byte_counter_nxt = bc_inc;
          res_nxt.transfer_valid = 1'b1; res_nxt.card_selected = 1'b1;
          case (bc_inc)
            8'd1:    res_nxt.tx_byte = command_latch_r[31:24];
            8'd2:    res_nxt.tx_byte = command_latch_r[23:16];
            8'd3:    res_nxt.tx_byte = command_latch_r[15:8];
            8'd4:    res_nxt.tx_byte = command_latch_r[7:0];
            8'd5:    res_nxt.tx_byte = CRC_BYTE;
            default: begin
              res_nxt.tx_byte = IDLE_BYTE;
              poll_counter_nxt = 16'd0;
              phase_nxt = PH_POLL;
            end
          endcase
        end
        PH_POLL: begin
          poll_counter_nxt = pc_inc;
          if (pc_inc >= cfg.poll_limit) begin
            fin = 1'b1; ok = 1'b0;
          end else begin
            res_nxt.transfer_valid = 1'b1; res_nxt.tx_byte = IDLE_BYTE;
            res_nxt.card_selected = 1'b1;
            if ((q_item.rx_byte & BIT7) == 8'd0) begin
              response_shift_nxt = {32'd0, q_item.rx_byte};
              case (kind_r)
                KIND_R2: bytes_remaining_nxt = 3'd2;
                KIND_R3: bytes_remaining_nxt = 3'd5;
                default: bytes_remaining_nxt = 3'd1;
              endcase
              phase_nxt = PH_CAPTURE;
            end
          end
        end
        PH_CAPTURE: begin
          if (bytes_remaining_r > 3'd1) begin
            response_shift_nxt = {response_shift_r[31:0], q_item.rx_byte};
            bytes_remaining_nxt = bytes_remaining_r - 3'd1;
            res_nxt.transfer_valid = 1'b1; res_nxt.tx_byte = IDLE_BYTE;
            res_nxt.card_selected = 1'b1;
          end else begin
            bytes_remaining_nxt = 3'd0;
            if (kind_r == KIND_R1B) begin
              phase_nxt = PH_BUSY;
              res_nxt.transfer_valid = 1'b1; res_nxt.tx_byte = IDLE_BYTE;
              res_nxt.card_selected = 1'b1;
            end else begin
              fin = 1'b1; ok = 1'b1;
            end
          end
        end
        PH_BUSY: begin
          if (q_item.rx_byte == IDLE_BYTE) phase_nxt = PH_BUSY_TAIL;
          res_nxt.transfer_valid = 1'b1; res_nxt.tx_byte = IDLE_BYTE;
          res_nxt.card_selected = 1'b1;
        end
        PH_BUSY_TAIL: begin
          fin = 1'b1; ok = 1'b1;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end

    if (fin) begin
      if (!init_r) begin
        phase_nxt = PH_IDLE;
        res_nxt.done_res = 1'b1;
        res_nxt.status = ok ? ST_OK : ST_NO_RESP;
        res_nxt.failed_step = ok ? FS_GO_IDLE : FS_PLAIN;
        res_nxt.response_word = ok ? response_shift_nxt : 40'd0;
      end else begin
        case (init_step_r)
          3'd0: begin
            if (!ok) begin
              fail = 1'b1; f_st = ST_NO_RESP; f_fs = FS_GO_IDLE;
            end else begin
              retry_counter_nxt = 16'd1; init_step_nxt = 3'd1;
              st_cmd = 1'b1; c_idx = 6'd55;
            end
          end
          3'd1: begin
            if (!ok) begin
              fail = 1'b1; f_st = ST_NO_RESP; f_fs = FS_IDLE_WT;
            end else begin
              init_step_nxt = 3'd2; st_cmd = 1'b1; c_idx = 6'd41;
            end
          end
          3'd2: begin
            if (response_shift_nxt[0] && (retry_counter_r < cfg.idle_retry_limit)) begin
              retry_counter_nxt = retry_counter_r + 16'd1; init_step_nxt = 3'd1;
              st_cmd = 1'b1; c_idx = 6'd55;
            end else if (retry_counter_r >= cfg.idle_retry_limit) begin
              fail = 1'b1; f_st = ST_RETRIES; f_fs = FS_IDLE_WT;
            end else begin
              init_step_nxt = 3'd3; st_cmd = 1'b1; c_idx = 6'd58; c_kind = KIND_R3;
            end
          end
          3'd3: begin
            if (!ok) begin
              fail = 1'b1; f_st = ST_NO_RESP; f_fs = FS_OCR;
            end else if ((response_shift_nxt[23:16] & cfg.ocr_voltage_mask)
                         != cfg.ocr_voltage_mask) begin
              fail = 1'b1; f_st = ST_VOLTAGE; f_fs = FS_OCR;
            end else begin
              init_step_nxt = 3'd4; st_cmd = 1'b1; c_idx = 6'd16;
              c_arg = cfg.block_length;
            end
          end
          default: begin
            fail = 1'b1;
            f_st = ok ? ST_OK : ST_NO_RESP;
            f_fs = ok ? FS_GO_IDLE : FS_SET_LEN;
          end
        endcase
        if (fail) begin
          phase_nxt = PH_IDLE; init_nxt = 1'b0;
          res_nxt.done_res = 1'b1; res_nxt.status = f_st;
          res_nxt.failed_step = f_fs; res_nxt.response_word = response_shift_nxt;
        end
      end
    end

    if (st_cmd) begin
      command_latch_nxt = {(c_idx & IDX_MASK) | CMD_START[5:0], 2'b01, c_arg} |
                          {CMD_START, 32'd0};
      command_latch_nxt[39:32] = {2'b01, c_idx};
      kind_nxt = c_kind;
      byte_counter_nxt = 8'd0;
      phase_nxt = PH_SEND;
      res_nxt = '0;
      res_nxt.transfer_valid = 1'b1; res_nxt.card_selected = 1'b1;
      res_nxt.tx_byte = {2'b01, c_idx};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= PH_IDLE;
      init_step_r       <= 3'd0;
      byte_counter_r    <= 8'd0;
      poll_counter_r    <= 16'd0;
      retry_counter_r   <= 16'd0;
      command_latch_r   <= 40'd0;
      response_shift_r  <= 40'd0;
      bytes_remaining_r <= 3'd0;
      kind_r            <= KIND_R1;
      init_r            <= 1'b0;
      res_valid_r       <= 1'b0;
    end else begin
      if (res_ready) res_valid_r <= 1'b0;
      if (q_pop) begin
        phase_r           <= phase_nxt;
        init_step_r       <= init_step_nxt;
        byte_counter_r    <= byte_counter_nxt;
        poll_counter_r    <= poll_counter_nxt;
        retry_counter_r   <= retry_counter_nxt;
        command_latch_r   <= command_latch_nxt;
        response_shift_r  <= response_shift_nxt;
        bytes_remaining_r <= bytes_remaining_nxt;
        kind_r            <= kind_nxt;
        init_r            <= init_nxt;
        res_valid_r       <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) res_r <= res_nxt;
  end

endmodule

// ----- hdl/sd_spi_init_and_command_engine.sv -----
// Top level of the SPI-mode SD command engine and init sequencer.
`timescale 1ns / 1ps
// Every accepted item produces exactly one result transfer. A start-command item
// begins one command, a start-init item begins the wake and init sequence, and
// each transfer-finished item carries the byte received on the SPI transfer that
// the previous result asked for. The engine takes one item per clock cycle unless a
// result waits untaken; the front part holds items in a two-entry queue, and the
// sequencer decides the next byte into a registered result stage, so a result that
// waits to be taken does not stop the next item from being queued. Configuration must
// be written only while the engine is idle.
module sd_spi_init_and_command_engine
  import sdspi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  sdspi_in_if.sink    in_ch,
  sdspi_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  cfg_t    cfg_r;
  item_t   in_item, q_item;
  logic    q_valid, q_pop, res_valid;
  result_t res;

  // Register file; writes to indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.poll_limit          <= 16'd255;
      cfg_r.idle_retry_limit    <= 16'd255;
      cfg_r.block_length        <= 32'd512;
      cfg_r.ocr_voltage_mask    <= 8'h30;
      cfg_r.wake_select_bytes   <= 8'd100;
      cfg_r.wake_deselect_bytes <= 8'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLL_LIMIT:  cfg_r.poll_limit          <= cfg_wdata[15:0];
        CFG_RETRY_LIMIT: cfg_r.idle_retry_limit    <= cfg_wdata[15:0];
        CFG_BLOCK_LEN:   cfg_r.block_length        <= cfg_wdata;
        CFG_OCR_MASK:    cfg_r.ocr_voltage_mask    <= cfg_wdata[7:0];
        CFG_WAKE_SEL:    cfg_r.wake_select_bytes   <= cfg_wdata[7:0];
        CFG_WAKE_DESEL:  cfg_r.wake_deselect_bytes <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign in_item.op            = in_ch.operation;
  assign in_item.command_index = in_ch.command_index;
  assign in_item.argument      = in_ch.argument;
  assign in_item.response_kind = in_ch.response_kind;
  assign in_item.rx_byte       = in_ch.rx_byte;

  sdspi_front u_front (
    .clk, .rst_n,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item,
    .q_valid, .q_pop, .q_item
  );

  sdspi_seq u_seq (
    .clk, .rst_n,
    .cfg       (cfg_r),
    .q_valid, .q_pop, .q_item,
    .res_valid,
    .res_ready (out_ch.ready),
    .res
  );

  assign out_ch.valid          = res_valid;
  assign out_ch.transfer_valid = res.transfer_valid;
  assign out_ch.tx_byte        = res.tx_byte;
  assign out_ch.card_selected  = res.card_selected;
  assign out_ch.done_res       = res.done_res;
  assign out_ch.status         = res.status;
  assign out_ch.failed_step    = res.failed_step;
  assign out_ch.response_word  = res.response_word;

`ifndef SYNTHESIS
  // A result never both requests a transfer and reports completion.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.transfer_valid && out_ch.done_res))
    else $error("transfer and completion reported together");
  // A requested transfer carries no status or response.
  a_xfer_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.transfer_valid) |-> (out_ch.status == ST_OK &&
      out_ch.response_word == 40'd0))
    else $error("transfer result carries status");
  // A plain success reports failed step zero.
  a_ok_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.done_res && out_ch.status == ST_OK) |->
      out_ch.failed_step == FS_GO_IDLE)
    else $error("success with a failed step");
`endif

endmodule

// ----- tb/tb_sd_spi_init_and_command_engine.sv -----
// Self-checking testbench for the SD SPI command engine and init sequencer.
`timescale 1ns / 1ps
module tb_sd_spi_init_and_command_engine;
  import sdspi_pkg::*;

  // Sequencer phases as the predictor tracks them.
  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_WAKE_SEL, SEQ_WAKE_DESEL, SEQ_SEND,
    SEQ_POLL, SEQ_CAPTURE, SEQ_BUSY, SEQ_BUSY_TAIL
  } seq_phase_e;

  // Traffic shapes: no idling, sender idles often, receiver stalls often, both now and then.
  typedef enum logic [1:0] {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SNK_STALL, FLOW_BOTH} flow_e;

  // One row of the directed table; chk marks a row whose result is typed in by hand.
  typedef struct {
    item_t   it;
    bit      chk;
    result_t res;
  } row_t;

  localparam int WATCHDOG_LIMIT = 50000;
  localparam int RAND_PER_PHASE = 150;
  localparam int NUM_PHASES     = 8;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_wdata;

  sdspi_in_if  in_ch ();
  sdspi_out_if out_ch ();

  sd_spi_init_and_command_engine u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 20 ns clock period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Predictor state: a copy of the sequencer and of its configuration registers.
  seq_phase_e  seq_phase;
  logic [2:0]  init_stage;
  logic [7:0]  byte_cnt;
  logic [15:0] poll_cnt;
  logic [15:0] round_cnt;
  logic [39:0] cmd_frame;
  logic [39:0] resp_shift;
  logic [2:0]  resp_left;
  logic [1:0]  kind_held;
  bit          in_init;
  cfg_t        cfg_copy;

  result_t     expected_results[$];
  flow_e       flow;
  int          failures;
  int          items_sent;
  int          results_seen;
  int          commands_closed;
  int          idle_cycles;

  // Result builders for the three shapes a result can take.
  function automatic result_t quiet_res();
    result_t r;
    r = '0;
    return r;
  endfunction

  function automatic result_t byte_req(logic [7:0] tx, logic cs);
    result_t r;
    r = '0;
    r.transfer_valid = 1'b1;
    r.tx_byte        = tx;
    r.card_selected  = cs;
    return r;
  endfunction

  function automatic result_t finished(logic [1:0] st, logic [2:0] fs, logic [39:0] word);
    result_t r;
    r = '0;
    r.done_res      = 1'b1;
    r.status        = st;
    r.failed_step   = fs;
    r.response_word = word;
    return r;
  endfunction

  task automatic launch_cmd(input logic [5:0] idx, input logic [31:0] arg,
                            input logic [1:0] kind, output result_t r);
    cmd_frame = {(8'(idx & IDX_MASK) | CMD_START), arg};
    kind_held = kind;
    byte_cnt  = '0;
    seq_phase = SEQ_SEND;
    r = byte_req(cmd_frame[39:32], 1'b1);
  endtask

  task automatic abort_init(input logic [1:0] st, input logic [2:0] fs, output result_t r);
    seq_phase = SEQ_IDLE;
    in_init   = 1'b0;
    r = finished(st, fs, resp_shift);
  endtask

  // One CMD55 + ACMD41 round begins with CMD55.
  task automatic app_cmd_round(output result_t r);
    round_cnt  = round_cnt + 16'd1;
    init_stage = 3'd1;
    launch_cmd(6'd55, 32'd0, KIND_R1, r);
  endtask

  task automatic go_idle_cmd(output result_t r);
    init_stage = 3'd0;
    launch_cmd(6'd0, 32'd0, KIND_R1, r);
  endtask

  task automatic end_select_wake(output result_t r);
    byte_cnt = '0;
    if (cfg_copy.wake_deselect_bytes != 8'd0) begin
      seq_phase = SEQ_WAKE_DESEL;
      r = byte_req(IDLE_BYTE, 1'b0);
    end else begin
      go_idle_cmd(r);
    end
  endtask

  // A command has closed: either report it, or move the init sequence on.
  task automatic close_cmd(input bit ok, output result_t r);
    if (!in_init) begin
      seq_phase = SEQ_IDLE;
      r = ok ? finished(ST_OK, FS_GO_IDLE, resp_shift) : finished(ST_NO_RESP, FS_PLAIN, '0);
    end else begin
      case (init_stage)
        3'd0: begin
          if (!ok) begin
            abort_init(ST_NO_RESP, FS_GO_IDLE, r);
          end else begin
            round_cnt = '0;
            app_cmd_round(r);
          end
        end
        3'd1: begin
          if (!ok) begin
            abort_init(ST_NO_RESP, FS_IDLE_WT, r);
          end else begin
            init_stage = 3'd2;
            launch_cmd(6'd41, 32'd0, KIND_R1, r);
          end
        end
        // A missing ACMD41 response leaves the idle bit of the last capture in place.
        3'd2: begin
          if (resp_shift[0] && round_cnt < cfg_copy.idle_retry_limit) begin
            app_cmd_round(r);
          end else if (round_cnt >= cfg_copy.idle_retry_limit) begin
            abort_init(ST_RETRIES, FS_IDLE_WT, r);
          end else begin
            init_stage = 3'd3;
            launch_cmd(6'd58, 32'd0, KIND_R3, r);
          end
        end
        3'd3: begin
          if (!ok) begin
            abort_init(ST_NO_RESP, FS_OCR, r);
          end else if ((resp_shift[23:16] & cfg_copy.ocr_voltage_mask)
                       != cfg_copy.ocr_voltage_mask) begin
            abort_init(ST_VOLTAGE, FS_OCR, r);
          end else begin
            init_stage = 3'd4;
            launch_cmd(6'd16, cfg_copy.block_length, KIND_R1, r);
          end
        end
        // The CMD16 response content is not examined.
        default: begin
          seq_phase = SEQ_IDLE;
          in_init   = 1'b0;
          r = ok ? finished(ST_OK, FS_GO_IDLE, resp_shift)
                 : finished(ST_NO_RESP, FS_SET_LEN, resp_shift);
        end
      endcase
    end
  endtask

  // Works out the result that one accepted item causes and advances the copy of the state.
  task automatic predict_step(input item_t it, output result_t r);
    r = quiet_res();
    if (seq_phase == SEQ_IDLE) begin
      if (it.op == OP_CMD) begin
        in_init = 1'b0;
        launch_cmd(it.command_index, it.argument, it.response_kind, r);
      end else if (it.op == OP_INIT) begin
        in_init    = 1'b1;
        init_stage = 3'd0;
        byte_cnt   = '0;
        if (cfg_copy.wake_select_bytes != 8'd0) begin
          seq_phase = SEQ_WAKE_SEL;
          r = byte_req(IDLE_BYTE, 1'b1);
        end else begin
          end_select_wake(r);
        end
      end
    end else if (it.op == OP_XFER) begin
      case (seq_phase)
        SEQ_WAKE_SEL: begin
          byte_cnt = byte_cnt + 8'd1;
          if (byte_cnt < cfg_copy.wake_select_bytes) r = byte_req(IDLE_BYTE, 1'b1);
          else end_select_wake(r);
        end
        SEQ_WAKE_DESEL: begin
          byte_cnt = byte_cnt + 8'd1;
          if (byte_cnt < cfg_copy.wake_deselect_bytes) r = byte_req(IDLE_BYTE, 1'b0);
          else go_idle_cmd(r);
        end
        SEQ_SEND: begin
          byte_cnt = byte_cnt + 8'd1;
          if (byte_cnt < 8'd5) begin
            r = byte_req(8'(cmd_frame >> (32 - 8 * byte_cnt)), 1'b1);
          end else if (byte_cnt == 8'd5) begin
            r = byte_req(CRC_BYTE, 1'b1);
          end else begin
            poll_cnt  = '0;
            seq_phase = SEQ_POLL;
            r = byte_req(IDLE_BYTE, 1'b1);
          end
        end
        // The limit wins even when the limit-th byte carries a start bit.
        SEQ_POLL: begin
          poll_cnt = poll_cnt + 16'd1;
          if (poll_cnt >= cfg_copy.poll_limit) begin
            close_cmd(1'b0, r);
          end else if ((it.rx_byte & BIT7) != 8'd0) begin
            r = byte_req(IDLE_BYTE, 1'b1);
          end else begin
            resp_shift = 40'(it.rx_byte);
            resp_left  = (kind_held == KIND_R2) ? 3'd2 : ((kind_held == KIND_R3) ? 3'd5 : 3'd1);
            seq_phase  = SEQ_CAPTURE;
            r = byte_req(IDLE_BYTE, 1'b1);
          end
        end
        SEQ_CAPTURE: begin
          if (resp_left > 3'd1) begin
            resp_shift = {resp_shift[31:0], it.rx_byte};
            resp_left  = resp_left - 3'd1;
            r = byte_req(IDLE_BYTE, 1'b1);
          end else begin
            resp_left = '0;
            if (kind_held == KIND_R1B) begin
              seq_phase = SEQ_BUSY;
              r = byte_req(IDLE_BYTE, 1'b1);
            end else begin
              close_cmd(1'b1, r);
            end
          end
        end
        SEQ_BUSY: begin
          if (it.rx_byte == IDLE_BYTE) seq_phase = SEQ_BUSY_TAIL;
          r = byte_req(IDLE_BYTE, 1'b1);
        end
        SEQ_BUSY_TAIL: close_cmd(1'b1, r);
        default: seq_phase = SEQ_IDLE;
      endcase
    end
  endtask

  // Plays the card: picks the byte it returns for the transfer now in progress.
  function automatic logic [7:0] card_byte();
    logic [7:0] b;
    b = 8'($urandom);
    case (seq_phase)
      SEQ_POLL:    b = ($urandom_range(0, 9) < 6) ? (b & ~BIT7) : (b | BIT7);
      SEQ_CAPTURE: if ($urandom_range(0, 1) == 0) b = IDLE_BYTE;
      SEQ_BUSY:    if ($urandom_range(0, 2) == 0) b = IDLE_BYTE;
      default:     ;
    endcase
    return b;
  endfunction

  // Next random item: mostly well-formed traffic, with some noise mixed in.
  function automatic item_t next_item();
    item_t it;
    it.op            = OP_XFER;
    it.command_index = 6'($urandom);
    it.argument      = $urandom;
    it.response_kind = 2'($urandom);
    it.rx_byte       = card_byte();
    if ($urandom_range(0, 99) < 7) begin
      it.op = 2'($urandom);
    end else if (seq_phase == SEQ_IDLE) begin
      it.op = ($urandom_range(0, 99) < 65) ? OP_CMD : OP_INIT;
    end
    return it;
  endfunction

  // Presents one item, waits for its transfer, then records what it should cause.
  // Each cycle before the item the sender stays idle with the chance of the phase.
  task automatic send_item(input item_t it, input bit chk, input result_t typed);
    result_t r;
    int      idle_pct;
    idle_pct = (flow == FLOW_SRC_IDLE) ? 80 : (flow == FLOW_BOTH) ? 33 : 0;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < idle_pct) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= it.op;
    in_ch.command_index <= it.command_index;
    in_ch.argument      <= it.argument;
    in_ch.response_kind <= it.response_kind;
    in_ch.rx_byte       <= it.rx_byte;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_step(it, r);
    expected_results.push_back(chk ? typed : r);
    items_sent++;
    if (r.done_res) commands_closed++;
  endtask

  // Raises the write enable for the write; the caller lowers it after the last write.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_POLL_LIMIT:  cfg_copy.poll_limit          = val[15:0];
      CFG_RETRY_LIMIT: cfg_copy.idle_retry_limit    = val[15:0];
      CFG_BLOCK_LEN:   cfg_copy.block_length        = val;
      CFG_OCR_MASK:    cfg_copy.ocr_voltage_mask    = val[7:0];
      CFG_WAKE_SEL:    cfg_copy.wake_select_bytes   = val[7:0];
      CFG_WAKE_DESEL:  cfg_copy.wake_deselect_bytes = val[7:0];
      default:         ;
    endcase
  endtask

  task automatic drain();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The receiver takes results or stalls according to the traffic shape of the phase.
  always @(posedge clk) begin
    if (flow == FLOW_SNK_STALL) out_ch.ready <= ($urandom_range(0, 99) >= 80);
    else if (flow == FLOW_BOTH) out_ch.ready <= ($urandom_range(0, 99) >= 33);
    else out_ch.ready <= 1'b1;
  end

  // Every accepted result is checked field by field against the oldest expectation.
  always @(posedge clk) begin : result_check
    result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result transfer arrived with nothing expected");
        failures++;
      end else begin
        e = expected_results.pop_front();
        if (out_ch.transfer_valid !== e.transfer_valid) begin
          $error("transfer_valid: expected %0h, got %0h", e.transfer_valid,
                 out_ch.transfer_valid);
          failures++;
        end
        if (out_ch.tx_byte !== e.tx_byte) begin
          $error("tx_byte: expected %0h, got %0h", e.tx_byte, out_ch.tx_byte);
          failures++;
        end
        if (out_ch.card_selected !== e.card_selected) begin
          $error("card_selected: expected %0h, got %0h", e.card_selected, out_ch.card_selected);
          failures++;
        end
        if (out_ch.done_res !== e.done_res) begin
          $error("done_res: expected %0h, got %0h", e.done_res, out_ch.done_res);
          failures++;
        end
        if (out_ch.status !== e.status) begin
          $error("status: expected %0h, got %0h", e.status, out_ch.status);
          failures++;
        end
        if (out_ch.failed_step !== e.failed_step) begin
          $error("failed_step: expected %0h, got %0h", e.failed_step, out_ch.failed_step);
          failures++;
        end
        if (out_ch.response_word !== e.response_word) begin
          $error("response_word: expected %0h, got %0h", e.response_word, out_ch.response_word);
          failures++;
        end
      end
    end
  end

  // The watchdog counts cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    row_t  rows[$];
    row_t  row;
    item_t it;
    int    n;

    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.operation     = OP_XFER;
    in_ch.command_index = '0;
    in_ch.argument      = '0;
    in_ch.response_kind = KIND_R1;
    in_ch.rx_byte       = '0;
    out_ch.ready        = 1'b0;
    flow                = FLOW_FREE;
    failures            = 0;
    items_sent          = 0;
    results_seen        = 0;
    commands_closed     = 0;
    idle_cycles         = 0;

    // The predictor starts from the reset state of the engine.
    seq_phase  = SEQ_IDLE;
    init_stage = '0;
    byte_cnt   = '0;
    poll_cnt   = '0;
    round_cnt  = '0;
    cmd_frame  = '0;
    resp_shift = '0;
    resp_left  = '0;
    kind_held  = KIND_R1;
    in_init    = 1'b0;
    cfg_copy   = '{16'd255, 16'd255, 32'd512, 8'h30, 8'd100, 8'd2};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, under the reset configuration. A transfer-finished item and the
    // unused operation code are both ignored while idle, and a start while busy is
    // ignored too; the R2 command below uses the extreme index and argument.
    row = '{'{OP_XFER, 6'h3F, 32'hFFFF_FFFF, KIND_R3, 8'hFF}, 1'b1, quiet_res()};
    rows.push_back(row);
    row = '{'{2'd3, 6'h00, 32'h0, KIND_R1, 8'h00}, 1'b1, quiet_res()};
    rows.push_back(row);
    row = '{'{OP_CMD, 6'h3F, 32'hFFFF_FFFF, KIND_R2, 8'h00}, 1'b1, byte_req(8'h7F, 1'b1)};
    rows.push_back(row);
    row = '{'{OP_INIT, 6'h00, 32'h0, KIND_R1, 8'h00}, 1'b1, quiet_res()};
    rows.push_back(row);
    for (int k = 0; k < 4; k++) begin
      row = '{'{OP_XFER, 6'h00, 32'h0, KIND_R1, 8'h00}, 1'b1, byte_req(IDLE_BYTE, 1'b1)};
      rows.push_back(row);
    end
    row = '{'{OP_XFER, 6'h00, 32'h0, KIND_R1, 8'h00}, 1'b1, byte_req(CRC_BYTE, 1'b1)};
    rows.push_back(row);
    row = '{'{OP_XFER, 6'h00, 32'h0, KIND_R1, 8'h00}, 1'b0, quiet_res()};
    rows.push_back(row);
    row = '{'{OP_XFER, 6'h00, 32'h0, KIND_R1, 8'h80}, 1'b0, quiet_res()};
    rows.push_back(row);
    row = '{'{OP_XFER, 6'h00, 32'h0, KIND_R1, 8'h00}, 1'b0, quiet_res()};
    rows.push_back(row);
    row = '{'{OP_XFER, 6'h00, 32'h0, KIND_R1, 8'hFF}, 1'b0, quiet_res()};
    rows.push_back(row);
    row = '{'{OP_XFER, 6'h00, 32'h0, KIND_R1, 8'hAA}, 1'b1,
            finished(ST_OK, FS_GO_IDLE, 40'h00_FF)};
    rows.push_back(row);
    // A minimal command: index and argument zero, R1b so that the busy wait is covered.
    row = '{'{OP_CMD, 6'h00, 32'h0, KIND_R1B, 8'h00}, 1'b1, byte_req(CMD_START, 1'b1)};
    rows.push_back(row);
    for (int k = 0; k < 6; k++) begin
      row = '{'{OP_XFER, 6'h00, 32'h0, KIND_R1, 8'h00}, 1'b0, quiet_res()};
      rows.push_back(row);
    end
    row = '{'{OP_XFER, 6'h00, 32'h0, KIND_R1, 8'h7F}, 1'b0, quiet_res()};
    rows.push_back(row);
    row = '{'{OP_XFER, 6'h00, 32'h0, KIND_R1, 8'h00}, 1'b0, quiet_res()};
    rows.push_back(row);
    row = '{'{OP_XFER, 6'h00, 32'h0, KIND_R1, 8'hFF}, 1'b0, quiet_res()};
    rows.push_back(row);
    row = '{'{OP_XFER, 6'h00, 32'h0, KIND_R1, 8'h00}, 1'b1,
            finished(ST_OK, FS_GO_IDLE, 40'h7F)};
    rows.push_back(row);
    foreach (rows[k]) send_item(rows[k].it, rows[k].chk, rows[k].res);

    // Random part: each phase after the first sets the registers while the engine is idle,
    // then runs mixed commands and init sequences under its own traffic shape. Both extremes
    // of every register but the poll and retry limits (lowest setting 1) appear among the settings.
    for (int p = 0; p < NUM_PHASES; p++) begin
      in_ch.valid <= 1'b0;
      flow = FLOW_FREE;
      drain();
      case (p)
        0: ;
        1: begin
          write_reg(CFG_POLL_LIMIT, 32'd1);
          write_reg(CFG_RETRY_LIMIT, 32'd1);
          write_reg(CFG_BLOCK_LEN, 32'd0);
          write_reg(CFG_OCR_MASK, 32'h00);
          write_reg(CFG_WAKE_SEL, 32'd0);
          write_reg(CFG_WAKE_DESEL, 32'd0);
        end
        2: begin
          write_reg(CFG_POLL_LIMIT, 32'd65535);
          write_reg(CFG_RETRY_LIMIT, 32'd65535);
          write_reg(CFG_BLOCK_LEN, 32'hFFFF_FFFF);
          write_reg(CFG_OCR_MASK, 32'hFF);
          write_reg(CFG_WAKE_SEL, 32'd255);
          write_reg(CFG_WAKE_DESEL, 32'd255);
        end
        default: begin
          write_reg(CFG_POLL_LIMIT, 32'($urandom_range(2, 8)));
          write_reg(CFG_RETRY_LIMIT, 32'($urandom_range(1, 6)));
          write_reg(CFG_BLOCK_LEN, $urandom);
          write_reg(CFG_OCR_MASK, ($urandom_range(0, 1) == 0) ? 32'h30 : 32'($urandom));
          write_reg(CFG_WAKE_SEL, 32'($urandom_range(0, 4)));
          write_reg(CFG_WAKE_DESEL, 32'($urandom_range(0, 3)));
        end
      endcase
      cfg_we <= 1'b0;
      flow = flow_e'(p % 4);
      n = 0;
      // Stop only once the engine is back to idle, so the next register write is safe.
      while (n < RAND_PER_PHASE || seq_phase != SEQ_IDLE) begin
        it = next_item();
        send_item(it, 1'b0, quiet_res());
        n++;
      end
    end

    in_ch.valid <= 1'b0;
    flow = FLOW_FREE;
    drain();
    repeat (10) @(posedge clk);
    $display("Covered %0d input transfers and %0d result transfers, %0d commands or inits",
             items_sent, results_seen, commands_closed);
    $display("closed, across %0d register settings and four traffic shapes.", NUM_PHASES);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
